FILE: rtl/core/jsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsr_pkg
// Shared types, sizes and controller codes of the first-fit slot reserver.
// ----------------------------------------------------------------------------
package jsr_pkg;

  localparam int JOBS         = 32;
  localparam int MACHINES     = 32;
  localparam int TIME_SLOTS   = 8192;
  localparam int MAX_DURATION = 63;

  localparam int WORD_BITS = 64;
  localparam int WORDS     = TIME_SLOTS / WORD_BITS;
  localparam int WORD_W    = $clog2(WORDS);
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int FIN_W     = $clog2(TIME_SLOTS);
  localparam int JOB_W     = $clog2(JOBS);
  localparam int MACH_W    = $clog2(MACHINES);
  localparam int ADDR_W    = MACH_W + WORD_W;
  localparam int MAP_DEPTH = MACHINES * WORDS;

  localparam int JOB_FW  = 5;
  localparam int MACH_FW = 5;
  localparam int DUR_FW  = 6;
  localparam int SLOT_W  = 13;

  typedef struct packed {
    logic [JOB_FW-1:0]  job;
    logic [MACH_FW-1:0] machine;
    logic [DUR_FW-1:0]  duration;
  } op_t;

  typedef struct packed {
    logic [SLOT_W-1:0] start_slot;
    logic [SLOT_W-1:0] finish_slot;
    logic [SLOT_W-1:0] makespan;
    logic              overflow;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_WR_CUR,
    ST_WR_PREV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic fetch;
    logic scan;
    logic wr_cur;
    logic wr_prev;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic early;
    logic hit;
    logic last_word;
    logic need_prev;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/jsr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module jsr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/jsr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsr_ctrl
// Sequencer: map clearing after reset, word accept, word scan, write-back, result.
// ----------------------------------------------------------------------------
module jsr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          op_valid,
  output logic               op_ready,
  output jsr_pkg::cmd_t      cmd,
  input  wire jsr_pkg::sts_t sts
);
  import jsr_pkg::*;

  state_t st, st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_CLEAR;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next  = st;
    cmd      = '0;
    op_ready = 1'b0;
    case (st)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) st_next = ST_IDLE;
      end
      ST_IDLE: begin
        op_ready = 1'b1;
        if (op_valid) begin
          cmd.load = 1'b1;
          st_next  = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        st_next   = sts.early ? ST_EMIT : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) st_next = ST_WR_CUR;
        else if (sts.last_word) st_next = ST_EMIT;
      end
      ST_WR_CUR: begin
        cmd.wr_cur = 1'b1;
        st_next    = sts.need_prev ? ST_WR_PREV : ST_EMIT;
      end
      ST_WR_PREV: begin
        cmd.wr_prev = 1'b1;
        st_next     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          st_next  = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_CLEAR;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_scan_entry: assert property (@(posedge clk) disable iff (rst)
    st == ST_SCAN |-> $past(st) == ST_FETCH || $past(st) == ST_SCAN)
    else $error("scan entered without a fetch");
  a_prev_after_cur: assert property (@(posedge clk) disable iff (rst)
    st == ST_WR_PREV |-> $past(st) == ST_WR_CUR)
    else $error("previous word written without current word");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    st == ST_CLEAR |-> !cmd.load && !cmd.wr_cur && !cmd.wr_prev)
    else $error("activity during map clearing");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/jsr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsr_datapath
// Occupancy map RAM, word-wide window search, finish table and result register.
// ----------------------------------------------------------------------------
module jsr_datapath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire jsr_pkg::cmd_t cmd,
  output jsr_pkg::sts_t      sts,
  input  wire jsr_pkg::op_t  op,
  output logic               res_valid,
  input  wire logic          res_ready,
  output jsr_pkg::res_t      res
);
  import jsr_pkg::*;

  localparam int CW = 2 * WORD_BITS;

  // item registers
  logic [JOB_W-1:0]     job_r;
  logic [MACH_W-1:0]    mach_r;
  logic [DUR_FW-1:0]    dur_r;
  logic                 range_bad;
  logic                 zero_r;
  logic [FIN_W-1:0]     fin_j;
  logic [CW-1:0]        wmask;

  // scan registers
  logic [WORD_W-1:0]    cur_w;
  logic                 first;
  logic [WORD_BITS-1:0] prev_m;
  logic [WORD_BITS-1:0] prev_raw;
  logic [WORD_BITS-1:0] cur_raw;
  logic [FIN_W-1:0]     found;
  logic                 miss;
  logic [ADDR_W-1:0]    clr_cnt;

  logic [FIN_W-1:0]     job_finish [JOBS];
  logic [FIN_W-1:0]     max_finish;

  // map RAM
  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [ADDR_W-1:0]    raddr;
  logic [WORD_BITS-1:0] q;

  logic [FIN_W:0]       s0;
  logic                 beyond;
  logic [WORD_W-1:0]    start_word;
  logic [OFF_W-1:0]     offset;
  logic [WORD_BITS-1:0] lowmask;
  logic [WORD_BITS-1:0] cur_m;
  logic [CW-1:0]        comb_w;
  logic [WORD_BITS-1:0] hit_vec;
  logic [OFF_W-1:0]     p_sel;
  logic [CW-1:0]        mark;
  logic [CW-1:0]        wmask_in;
  logic [FIN_W-1:0]     start_calc;
  logic [FIN_W-1:0]     max_new;

  jsr_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(q)
  );

  assign s0         = {1'b0, fin_j} + (FIN_W+1)'(1);
  assign beyond     = s0 >= (FIN_W+1)'(TIME_SLOTS);
  assign start_word = s0[FIN_W-1:OFF_W];
  assign offset     = s0[OFF_W-1:0];

  // window mask: dur ones ending at bit WORD_BITS of the two-word view
  always_comb begin
    for (int i = 0; i < CW; i++) begin
      wmask_in[i] = (i <= WORD_BITS) && (i + int'(op.duration) >= WORD_BITS + 1);
    end
  end

  // slots before the scan start count as busy in the first word
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      lowmask[i] = first && (i < int'(offset));
    end
  end

  assign cur_m  = q | lowmask;
  assign comb_w = {cur_m, prev_m};

  always_comb begin
    for (int p = 0; p < WORD_BITS; p++) begin
      hit_vec[p] = ~|(comb_w & (wmask << p));
    end
  end

  always_comb begin
    p_sel = '0;
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (hit_vec[p]) p_sel = OFF_W'(p);
    end
  end

  // slots to mark, placed in the two-word view around the found end slot
  always_comb begin
    for (int i = 0; i < CW; i++) begin
      mark[i] = (i <= WORD_BITS + int'(found[OFF_W-1:0])) &&
                (i + int'(dur_r) >= WORD_BITS + 1 + int'(found[OFF_W-1:0]));
    end
  end

  always_comb begin
    we    = cmd.clr || cmd.wr_cur || cmd.wr_prev;
    waddr = {mach_r, cur_w};
    wdata = cur_raw | mark[CW-1:WORD_BITS];
    if (cmd.clr) begin
      waddr = clr_cnt;
      wdata = '0;
    end else if (cmd.wr_prev) begin
      waddr = {mach_r, cur_w - WORD_W'(1)};
      wdata = prev_raw | mark[WORD_BITS-1:0];
    end
    raddr = cmd.fetch ? {mach_r, start_word} : {mach_r, cur_w + WORD_W'(1)};
  end

  assign start_calc = found - FIN_W'(dur_r) + FIN_W'(1);
  assign max_new    = (found > max_finish) ? found : max_finish;

  always_comb begin
    sts.clr_last  = clr_cnt == ADDR_W'(MAP_DEPTH - 1);
    sts.early     = range_bad || zero_r || beyond;
    sts.hit       = |hit_vec;
    sts.last_word = cur_w == WORD_W'(WORDS - 1);
    sts.need_prev = int'(dur_r) > int'(found[OFF_W-1:0]) + 1;
    sts.out_busy  = res_valid && !res_ready;
  end

  // item and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      job_r     <= op.job[JOB_W-1:0];
      mach_r    <= op.machine[MACH_W-1:0];
      dur_r     <= op.duration;
      range_bad <= int'(op.job) >= JOBS || int'(op.machine) >= MACHINES ||
                   int'(op.duration) > MAX_DURATION;
      zero_r    <= op.duration == '0;
      fin_j     <= job_finish[op.job[JOB_W-1:0]];
      wmask     <= wmask_in;
    end
    if (cmd.fetch) begin
      cur_w    <= start_word;
      first    <= 1'b1;
      prev_m   <= '1;
      prev_raw <= '0;
      miss     <= range_bad || (!zero_r && beyond);
    end
    if (cmd.scan) begin
      if (sts.hit) begin
        found   <= {cur_w, p_sel};
        cur_raw <= q;
      end else begin
        cur_w    <= cur_w + WORD_W'(1);
        first    <= 1'b0;
        prev_m   <= cur_m;
        prev_raw <= q;
        if (sts.last_word) miss <= 1'b1;
      end
    end
  end

  // finish table and makespan
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < JOBS; j++) begin
        job_finish[j] <= '0;
      end
      max_finish <= '0;
    end else if (cmd.emit && !miss && !zero_r) begin
      job_finish[job_r] <= found;
      max_finish        <= max_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (miss) begin
        res <= '{start_slot: '0, finish_slot: '0,
                 makespan: SLOT_W'(max_finish), overflow: 1'b1};
      end else if (zero_r) begin
        res <= '{start_slot: SLOT_W'(fin_j), finish_slot: SLOT_W'(fin_j),
                 makespan: SLOT_W'(max_finish), overflow: 1'b0};
      end else begin
        res <= '{start_slot: SLOT_W'(start_calc), finish_slot: SLOT_W'(found),
                 makespan: SLOT_W'(max_new), overflow: 1'b0};
      end
    end
  end

`ifndef SYNTHESIS
  a_scan_steps: assert property (@(posedge clk) disable iff (rst)
    cmd.scan && !sts.hit && !sts.last_word |=> cur_w == $past(cur_w) + WORD_W'(1))
    else $error("scan skipped a word");
  a_window_after_start: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_cur |-> {1'b0, found} + (FIN_W+1)'(1) >= s0 + (FIN_W+1)'(dur_r))
    else $error("window begins before the job's finish");
  a_window_length: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && !miss && !zero_r |=>
      res.finish_slot - res.start_slot == SLOT_W'(dur_r) - SLOT_W'(1))
    else $error("reserved window length differs from duration");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/job_shop_first_fit_slot_reserver_unit.sv
// Each request word is scanned from its start word through at most 128 map
//   words, one 64-slot map word per cycle; a window that crosses a word
//   boundary also rewrites the previous word. A zero duration, an out-of-range
//   request or a job already at the horizon skips the scan. A stalled result
//   word holds back the next one. One word per item at a time; the next word
//   can be accepted in the cycle after the result is loaded.
// Reset: clears all 4096 words of the map RAM; no word accepted meanwhile.
`default_nettype none
// ----------------------------------------------------------------------------
// job_shop_first_fit_slot_reserver_unit
// First-fit reservation of consecutive free slots on a machine's occupancy map.
// ----------------------------------------------------------------------------
module job_shop_first_fit_slot_reserver_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         op_valid,
  output logic              op_ready,
  input  wire jsr_pkg::op_t op,
  output logic              res_valid,
  input  wire logic         res_ready,
  output jsr_pkg::res_t     res
);
  import jsr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  jsr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .op_valid(op_valid),
    .op_ready(op_ready),
    .cmd     (cmd),
    .sts     (sts)
  );

  jsr_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .op       (op),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

endmodule
`default_nettype wire

FILE: bench/job_shop_first_fit_slot_reserver_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// job_shop_first_fit_slot_reserver_unit_tb
// Self-checking bench for the first-fit slot reserver. A shadow copy of the
// machine occupancy maps, job finish times and makespan predicts each result
// from every accepted request word. Results are compared field by field in
// order. Both handshakes see random idle bursts.
// ----------------------------------------------------------------------------
module job_shop_first_fit_slot_reserver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jsr_pkg::*;

  localparam int END_WAIT    = 200;
  localparam int DRAIN_LIMIT = 50000;
  localparam int JOB_MAX     = (1 << JOB_FW) - 1;
  localparam int MACH_MAX    = (1 << MACH_FW) - 1;
  localparam int DUR_MAX     = (1 << DUR_FW) - 1;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic op_valid  = 1'b0;
  logic res_ready = 1'b0;
  op_t  op        = '0;
  logic op_ready;
  logic res_valid;
  res_t res;

  int op_gap_pct    = 0;
  int res_stall_pct = 0;
  int stall_left    = 0;

  class reservation_scoreboard;
    bit [TIME_SLOTS-1:0] busy [MACHINES];
    logic [SLOT_W-1:0]   job_fin [JOBS];
    logic [SLOT_W-1:0]   span;
    res_t                due_results [$];
    int                  errors;
    int                  n_checked;
    int                  n_overflow;
    int                  n_zero;

    function new();
      foreach (busy[m]) busy[m] = '0;
      foreach (job_fin[j]) job_fin[j] = '0;
      span       = '0;
      errors     = 0;
      n_checked  = 0;
      n_overflow = 0;
      n_zero     = 0;
    endfunction

    function logic [SLOT_W-1:0] finish_of(int j);
      return job_fin[j];
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // First-fit search after the job's finish slot; marks the window on a hit.
    function res_t reserve(op_t o);
      res_t r;
      int   j;
      int   m;
      int   d;
      int   run;
      int   first;
      r = '0;
      j = o.job;
      m = o.machine;
      d = o.duration;
      if (j >= JOBS || m >= MACHINES || d > MAX_DURATION) begin
        r.makespan = span;
        r.overflow = 1'b1;
        return r;
      end
      if (d == 0) begin
        r.start_slot  = job_fin[j];
        r.finish_slot = job_fin[j];
        r.makespan    = span;
        return r;
      end
      run = 0;
      for (int s = int'(job_fin[j]) + 1; s < TIME_SLOTS; s++) begin
        if (busy[m][s]) begin
          run = 0;
        end else begin
          run++;
          if (run == d) begin
            first = s + 1 - d;
            for (int k = first; k <= s; k++) busy[m][k] = 1'b1;
            job_fin[j] = SLOT_W'(s);
            if (s > int'(span)) span = SLOT_W'(s);
            r.start_slot  = SLOT_W'(first);
            r.finish_slot = SLOT_W'(s);
            r.makespan    = span;
            return r;
          end
        end
      end
      // nothing fits below the horizon: no reservation
      r.makespan = span;
      r.overflow = 1'b1;
      return r;
    endfunction

    function void note_request(op_t o);
      res_t r;
      r = reserve(o);
      if (o.duration == 0) n_zero++;
      if (r.overflow) n_overflow++;
      due_results.push_back(r);
    endfunction

    task check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        report("result word with nothing pending");
        return;
      end
      want = due_results.pop_front();
      n_checked++;
      if (got.start_slot !== want.start_slot)
        report($sformatf("start_slot got %0d want %0d", got.start_slot, want.start_slot));
      if (got.finish_slot !== want.finish_slot)
        report($sformatf("finish_slot got %0d want %0d", got.finish_slot, want.finish_slot));
      if (got.makespan !== want.makespan)
        report($sformatf("makespan got %0d want %0d", got.makespan, want.makespan));
      if (got.overflow !== want.overflow)
        report($sformatf("overflow got %0b want %0b", got.overflow, want.overflow));
    endtask
  endclass

  reservation_scoreboard sb;

  job_shop_first_fit_slot_reserver_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ready = 1'b0;
      stall_left--;
    end else if (res_stall_pct > 0 && $urandom_range(0, 99) < res_stall_pct) begin
      res_ready  = 1'b0;
      stall_left = $urandom_range(1, 8) - 1;
    end else begin
      res_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_ready === 1'b1) sb.check_result(res);
  end

  task automatic send_op(input int j, input int m, input int d);
    op_t o;
    o = '{job: JOB_FW'(j), machine: MACH_FW'(m), duration: DUR_FW'(d)};
    @(negedge clk);
    if (op_gap_pct > 0 && $urandom_range(0, 99) < op_gap_pct) begin
      op_valid = 1'b0;
      op       = op_t'($urandom);
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    op       = o;
    op_valid = 1'b1;
    do @(posedge clk); while (op_ready !== 1'b1);
    sb.note_request(o);
  endtask

  // drop valid so the last word is not taken twice
  task automatic release_op();
    @(negedge clk);
    op_valid = 1'b0;
  endtask

  task automatic send_random();
    int d;
    d = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, DUR_MAX);
    send_op($urandom_range(0, JOB_MAX), $urandom_range(0, MACH_MAX), d);
  endtask

  // Drive one job up to the horizon, mixed with unrelated words.
  // fixed_m < 0 spreads the job over random machines.
  task automatic push_to_horizon(input int j, input int fixed_m, input int n);
    int f;
    int m;
    int d;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_random();
      end else begin
        f = sb.finish_of(j);
        m = (fixed_m >= 0) ? fixed_m : $urandom_range(0, MACH_MAX);
        if (f < TIME_SLOTS - 192)
          d = MAX_DURATION;
        else if (f < TIME_SLOTS - 1 && $urandom_range(0, 1) == 1)
          d = (TIME_SLOTS - 1 - f > MAX_DURATION) ? MAX_DURATION : TIME_SLOTS - 1 - f;
        else
          d = $urandom_range(0, DUR_MAX);
        send_op(j, m, d);
      end
    end
  endtask

  task automatic wait_all_results();
    release_op();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int cycles;
    sb = new();
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: extremes, zero length, word-boundary windows, gap skipping
    send_op(0, 0, 1);
    send_op(0, 0, 0);
    send_op(1, 0, 63);
    send_op(31, 31, 63);
    send_op(31, 31, 1);
    send_op(2, 0, 1);
    send_op(3, 31, 0);
    send_op(4, 0, 63);
    send_op(1, 31, 10);
    send_op(5, 1, 32);
    send_op(5, 1, 32);
    send_op(6, 2, 63);
    send_op(7, 2, 1);
    send_op(1, 5, 4);
    send_op(14, 5, 63);
    send_op(15, 5, 20);
    send_op(15, 5, 0);
    send_op(31, 0, 63);
    send_op(16, 31, 62);
    send_op(17, 17, 1);

    op_gap_pct    = 25;
    res_stall_pct = 15;
    for (int i = 0; i < 150; i++) send_random();

    op_gap_pct    = 0;
    res_stall_pct = 0;
    for (int i = 0; i < 100; i++) send_random();

    wait_all_results();

    op_gap_pct    = 20;
    res_stall_pct = 20;
    push_to_horizon(9, 12, 190);

    op_gap_pct    = 10;
    res_stall_pct = 5;
    push_to_horizon(22, -1, 190);

    // machine 12 is now mostly full, so aim a share of words at it
    op_gap_pct    = 30;
    res_stall_pct = 25;
    for (int i = 0; i < 130; i++) begin
      if ($urandom_range(0, 2) == 0)
        send_op($urandom_range(0, JOB_MAX), 12, $urandom_range(0, DUR_MAX));
      else
        send_random();
    end

    // closing stretch without idling
    op_gap_pct    = 0;
    res_stall_pct = 0;
    for (int i = 0; i < 120; i++) send_random();

    release_op();
    cycles = 0;
    while (sb.pending() != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    repeat (END_WAIT) @(posedge clk);

    $display("Checked %0d results: %0d overflows, %0d zero-length requests",
             sb.n_checked, sb.n_overflow, sb.n_zero);
    $display("Two jobs driven to the horizon, final makespan %0d", sb.span);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/jsr_pkg.sv
rtl/core/jsr_ram.sv
rtl/core/jsr_ctrl.sv
rtl/core/jsr_datapath.sv
rtl/core/job_shop_first_fit_slot_reserver_unit.sv
bench/job_shop_first_fit_slot_reserver_unit_tb.sv
